FILE: hw/rtl/framed_packet_ring_buffer_macros.svh
// Assertion macros shared by the ring buffer RTL.
// Each macro checks one implication on the rising edge of the given clock.
// Checks are suspended while the active-low reset is asserted.
`ifndef FRAMED_PACKET_RING_BUFFER_MACROS_SVH
`define FRAMED_PACKET_RING_BUFFER_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define FPRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FPRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define FPRB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)

`define FPRB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: hw/rtl/fprb_pkg.sv
`timescale 1ns / 1ps

package fprb_pkg;

  // Default store depth in bytes.
  localparam int FPRB_DEPTH = 256;

  // Frame marker bytes.
  localparam logic [7:0] HDR_BYTE = 8'h5C;
  localparam logic [7:0] TRL_BYTE = 8'hCA;

  // Scale of the usage figure.
  localparam int USAGE_SCALE = 100;

  // Request codes.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  // Fill status codes.
  localparam logic [1:0] ST_EMPTY = 2'd0;
  localparam logic [1:0] ST_USE   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Configuration register indexes and reset values.
  localparam int         CFG_IDX_W  = 1;
  localparam int         CFG_DATA_W = 9;
  localparam logic [0:0] CFG_FRAMED = 1'b0;
  localparam logic [0:0] CFG_MARGIN = 1'b1;
  localparam logic [8:0] MARGIN_RST = 9'd32;

  // Write data select for a push.
  localparam logic [1:0] PSEL_HDR = 2'd0;
  localparam logic [1:0] PSEL_LEN = 2'd1;
  localparam logic [1:0] PSEL_DIN = 2'd2;
  localparam logic [1:0] PSEL_TRL = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       push;
    logic [1:0] push_sel;
    logic       pop;
    logic       set_dout;
    logic       mark_last;
    logic       dec_rd;
    logic       latch_len;
    logic       set_wr;
    logic       dec_wr;
    logic       clr_pkt;
    logic       set_ovf;
    logic       clear;
    logic       fin;
    logic       load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op_func;
    logic       framed;
    logic       in_packet;
    logic       wr_rem_zero;
    logic       wr_rem_one;
    logic       rd_rem_zero;
    logic       rd_rem_one;
    logic       fill_zero;
    logic       fill_ge2;
    logic       start_no_room;
    logic       byte_no_room;
    logic       raw_no_room;
    logic       rd_is_hdr;
    logic       rd_is_trl;
    logic       plen_zero;
    logic       out_free;
  } sts_t;

endpackage

FILE: hw/rtl/fprb_ram.sv
`timescale 1ns / 1ps

module fprb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port and one registered read port; a read of the address
  // being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/fprb_dp.sv
`timescale 1ns / 1ps
`include "framed_packet_ring_buffer_macros.svh"

module fprb_dp import fprb_pkg::*; #(
  parameter int DEPTH = FPRB_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_packet_len,
  input  logic [7:0]            in_data_in,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [7:0]            out_data_out,
  output logic                  out_data_valid,
  output logic                  out_last_byte,
  output logic [7:0]            out_packet_length,
  output logic [1:0]            out_buffer_status,
  output logic [6:0]            out_usage_percent,
  output logic                  out_overflow
);

  localparam int AW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int SW  = ((CW > CFG_DATA_W) ? CW : CFG_DATA_W) + 1;
  localparam int RW  = CW + 1;
  localparam int U_A = USAGE_SCALE / DEPTH;
  localparam int U_B = USAGE_SCALE % DEPTH;
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

  // Ring pointers, fill and the running usage quotient and remainder.
  logic [AW-1:0] head_r, head_nxt, tail_r, tail_nxt, head_adv, tail_adv;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [6:0]    usage_r, usage_nxt;
  logic [AW-1:0] urem_r, urem_nxt;
  logic [RW-1:0] urem_up;
  logic [1:0]    fstat_r, fstat_nxt;
  logic          full_hit;

  // Packet counters and configuration.
  logic [7:0] wr_rem_r, rd_rem_r, plen_lat_r;
  logic       in_pkt_r;
  logic       framed_r;
  logic [8:0] margin_r;

  // Current request and its per-request results.
  logic [1:0] op_func_r;
  logic [7:0] op_plen_r, op_data_r, op_dout_r;
  logic       op_valid_r, op_last_r, op_ovf_r, wrote_r, popped_r;

  // Output word register.
  logic       out_valid_r;
  logic [7:0] out_dout_r, out_plen_r;
  logic       out_dvalid_r, out_last_r, out_ovf_r;
  logic [1:0] out_stat_r;
  logic [6:0] out_usage_r;

  // Store interface.
  logic [7:0] wr_byte, rd_data;

  assign head_adv = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign tail_adv = (tail_r == LAST_IDX) ? '0 : tail_r + 1'b1;
  assign urem_up  = RW'(urem_r) + RW'(U_B);

  // Pointer, fill and usage update; usage_r * DEPTH + urem_r always equals
  // fill_r * 100, and the fill moves by at most one byte per cycle.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    fill_nxt  = fill_r;
    usage_nxt = usage_r;
    urem_nxt  = urem_r;
    if (cmd_i.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      fill_nxt  = '0;
      usage_nxt = '0;
      urem_nxt  = '0;
    end else if (cmd_i.push) begin
      head_nxt = head_adv;
      fill_nxt = fill_r + 1'b1;
      if (urem_up >= RW'(DEPTH)) begin
        urem_nxt  = AW'(urem_up - RW'(DEPTH));
        usage_nxt = usage_r + 7'(U_A + 1);
      end else begin
        urem_nxt  = AW'(urem_up);
        usage_nxt = usage_r + 7'(U_A);
      end
    end else if (cmd_i.pop) begin
      tail_nxt = tail_adv;
      fill_nxt = fill_r - 1'b1;
      if (RW'(urem_r) < RW'(U_B)) begin
        urem_nxt  = AW'(RW'(urem_r) + RW'(DEPTH) - RW'(U_B));
        usage_nxt = usage_r - 7'(U_A + 1);
      end else begin
        urem_nxt  = AW'(RW'(urem_r) - RW'(U_B));
        usage_nxt = usage_r - 7'(U_A);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      fill_r  <= '0;
      usage_r <= '0;
      urem_r  <= '0;
      fstat_r <= ST_EMPTY;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      fill_r  <= fill_nxt;
      usage_r <= usage_nxt;
      urem_r  <= urem_nxt;
      fstat_r <= fstat_nxt;
    end
  end

  // Status moves once per request, from the final fill of that request.
  assign full_hit = (SW'(fill_r) + SW'(margin_r)) > SW'(DEPTH);

  always_comb begin
    fstat_nxt = fstat_r;
    if (cmd_i.clear) begin
      fstat_nxt = ST_EMPTY;
    end else if (cmd_i.fin && wrote_r) begin
      case (fstat_r)
        ST_EMPTY: fstat_nxt = ST_USE;
        ST_USE:   fstat_nxt = full_hit ? ST_FULL : ST_USE;
        default:  fstat_nxt = fstat_r;
      endcase
    end else if (cmd_i.fin && popped_r) begin
      case (fstat_r)
        ST_FULL: fstat_nxt = ST_USE;
        ST_USE:  fstat_nxt = (fill_r == '0) ? ST_EMPTY : ST_USE;
        default: fstat_nxt = fstat_r;
      endcase
    end
  end

  // Byte to store on a push.
  always_comb begin
    unique case (cmd_i.push_sel)
      PSEL_HDR: wr_byte = HDR_BYTE;
      PSEL_LEN: wr_byte = op_plen_r;
      PSEL_DIN: wr_byte = op_data_r;
      PSEL_TRL: wr_byte = TRL_BYTE;
      default:  wr_byte = op_data_r;
    endcase
  end

  // The read port follows the next tail, so rd_data holds the byte at the
  // tail during every read step. Entries outside the fill window are never
  // read, so the store needs no clearing pass and no zeroing on a pop.
  fprb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd_i.push),
    .waddr (head_r),
    .wdata (wr_byte),
    .raddr (tail_nxt),
    .rdata (rd_data)
  );

  // Packet write and read counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_rem_r   <= '0;
      rd_rem_r   <= '0;
      plen_lat_r <= '0;
      in_pkt_r   <= 1'b0;
    end else if (cmd_i.clear) begin
      wr_rem_r   <= '0;
      rd_rem_r   <= '0;
      plen_lat_r <= '0;
      in_pkt_r   <= 1'b0;
    end else begin
      if (cmd_i.set_wr) begin
        wr_rem_r <= op_plen_r;
      end else if (cmd_i.dec_wr) begin
        wr_rem_r <= wr_rem_r - 1'b1;
      end
      if (cmd_i.latch_len) begin
        plen_lat_r <= rd_data;
        rd_rem_r   <= rd_data;
        in_pkt_r   <= 1'b1;
      end else begin
        if (cmd_i.dec_rd) begin
          rd_rem_r <= rd_rem_r - 1'b1;
        end
        if (cmd_i.clr_pkt) begin
          in_pkt_r <= 1'b0;
        end
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      framed_r <= 1'b1;
      margin_r <= MARGIN_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAMED: framed_r <= cfg_wdata[0];
        CFG_MARGIN: margin_r <= cfg_wdata;
        default:    framed_r <= framed_r;
      endcase
    end
  end

  // Request capture and per-request result flags.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      op_func_r <= in_func;
      op_plen_r <= in_packet_len;
      op_data_r <= in_data_in;
      op_dout_r <= '0;
    end else if (cmd_i.set_dout) begin
      op_dout_r <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.capture) begin
      op_valid_r <= 1'b0;
      op_last_r  <= 1'b0;
      op_ovf_r   <= 1'b0;
      wrote_r    <= 1'b0;
      popped_r   <= 1'b0;
    end else begin
      if (cmd_i.set_dout) begin
        op_valid_r <= 1'b1;
      end
      if (cmd_i.mark_last) begin
        op_last_r <= 1'b1;
      end
      if (cmd_i.set_ovf) begin
        op_ovf_r <= 1'b1;
      end
      if (cmd_i.push) begin
        wrote_r <= 1'b1;
      end
      if (cmd_i.pop) begin
        popped_r <= 1'b1;
      end
    end
  end

  // Output word register: loaded only once the previous word is gone or taken in that cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_dout_r   <= op_dout_r;
      out_dvalid_r <= op_valid_r;
      out_last_r   <= op_last_r;
      out_plen_r   <= plen_lat_r;
      out_stat_r   <= fstat_r;
      out_usage_r  <= usage_r;
      out_ovf_r    <= op_ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_data_out      = out_dout_r;
  assign out_data_valid    = out_dvalid_r;
  assign out_last_byte     = out_last_r;
  assign out_packet_length = out_plen_r;
  assign out_buffer_status = out_stat_r;
  assign out_usage_percent = out_usage_r;
  assign out_overflow      = out_ovf_r;

  // Status to the controller.
  always_comb begin
    sts_o.op_func       = op_func_r;
    sts_o.framed        = framed_r;
    sts_o.in_packet     = in_pkt_r;
    sts_o.wr_rem_zero   = (wr_rem_r == 8'd0);
    sts_o.wr_rem_one    = (wr_rem_r == 8'd1);
    sts_o.rd_rem_zero   = (rd_rem_r == 8'd0);
    sts_o.rd_rem_one    = (rd_rem_r == 8'd1);
    sts_o.fill_zero     = (fill_r == '0);
    sts_o.fill_ge2      = (fill_r >= CW'(2));
    sts_o.start_no_room = (SW'(fill_r) + SW'(op_plen_r) + SW'(3)) > SW'(DEPTH);
    sts_o.byte_no_room  = (SW'(fill_r) + (wr_rem_r == 8'd1 ? SW'(2) : SW'(1)))
                          > SW'(DEPTH);
    sts_o.raw_no_room   = (fill_r == DEPTH_C);
    sts_o.rd_is_hdr     = (rd_data == HDR_BYTE);
    sts_o.rd_is_trl     = (rd_data == TRL_BYTE);
    sts_o.plen_zero     = (op_plen_r == 8'd0);
    sts_o.out_free      = !out_valid_r || out_ready;
  end

  // Checks on the store bookkeeping.
  `FPRB_ASSERT_IMP(a_push_pop_excl, clk, rst_n, cmd_i.push, !cmd_i.pop, "push and pop together")
  `FPRB_ASSERT_IMP(a_push_room, clk, rst_n, cmd_i.push, fill_r < DEPTH_C, "push into a full store")
  `FPRB_ASSERT_IMP(a_pop_data, clk, rst_n, cmd_i.pop, fill_r != '0, "pop from an empty store")
  `FPRB_ASSERT_IMP(a_usage_zero, clk, rst_n, fill_r == '0, (usage_r == '0) && (urem_r == '0), "usage out of step with fill")
  `FPRB_ASSERT_NXT(a_write_status, clk, rst_n, cmd_i.fin && wrote_r && !cmd_i.clear, fstat_r != ST_EMPTY, "empty status after a write")

endmodule

FILE: hw/rtl/fprb_ctrl.sv
`timescale 1ns / 1ps

module fprb_ctrl import fprb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_EXEC     = 4'd1;
  localparam logic [3:0] S_PUSH_HDR = 4'd2;
  localparam logic [3:0] S_PUSH_LEN = 4'd3;
  localparam logic [3:0] S_PUSH_TRL = 4'd4;
  localparam logic [3:0] S_RD_SCAN  = 4'd5;
  localparam logic [3:0] S_RD_LEN   = 4'd6;
  localparam logic [3:0] S_RD_DATA  = 4'd7;
  localparam logic [3:0] S_RD_TRL   = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;
  localparam logic [3:0] S_OUT      = 4'd10;

  logic [3:0] state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Sequencer: one store access per cycle, then status update and output.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_EXEC;
        end
      end

      S_EXEC: begin
        state_nxt = S_FIN;
        case (sts_i.op_func)
          FUNC_START: begin
            if (sts_i.framed && sts_i.wr_rem_zero) begin
              if (sts_i.start_no_room) begin
                cmd_o.set_ovf = 1'b1;
              end else begin
                state_nxt = S_PUSH_HDR;
              end
            end
          end
          FUNC_WRITE: begin
            if (sts_i.framed) begin
              if (!sts_i.wr_rem_zero) begin
                if (sts_i.byte_no_room) begin
                  cmd_o.set_ovf = 1'b1;
                end else begin
                  cmd_o.push     = 1'b1;
                  cmd_o.push_sel = PSEL_DIN;
                  cmd_o.dec_wr   = 1'b1;
                  if (sts_i.wr_rem_one) begin
                    state_nxt = S_PUSH_TRL;
                  end
                end
              end
            end else if (sts_i.raw_no_room) begin
              cmd_o.set_ovf = 1'b1;
            end else begin
              cmd_o.push     = 1'b1;
              cmd_o.push_sel = PSEL_DIN;
            end
          end
          FUNC_READ: begin
            if (sts_i.framed) begin
              state_nxt = sts_i.in_packet ? S_RD_DATA : S_RD_SCAN;
            end else if (!sts_i.fill_zero) begin
              cmd_o.pop      = 1'b1;
              cmd_o.set_dout = 1'b1;
            end
          end
          default: begin
            cmd_o.clear = 1'b1;
          end
        endcase
      end

      S_PUSH_HDR: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PSEL_HDR;
        state_nxt      = S_PUSH_LEN;
      end

      S_PUSH_LEN: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PSEL_LEN;
        cmd_o.set_wr   = 1'b1;
        state_nxt      = sts_i.plen_zero ? S_PUSH_TRL : S_FIN;
      end

      S_PUSH_TRL: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sel = PSEL_TRL;
        state_nxt      = S_FIN;
      end

      // Drop bytes up to a header; a header with no length behind it stays.
      S_RD_SCAN: begin
        if (sts_i.fill_zero) begin
          state_nxt = S_FIN;
        end else if (!sts_i.rd_is_hdr) begin
          cmd_o.pop = 1'b1;
        end else if (sts_i.fill_ge2) begin
          cmd_o.pop = 1'b1;
          state_nxt = S_RD_LEN;
        end else begin
          state_nxt = S_FIN;
        end
      end

      S_RD_LEN: begin
        cmd_o.pop       = 1'b1;
        cmd_o.latch_len = 1'b1;
        state_nxt       = S_RD_DATA;
      end

      S_RD_DATA: begin
        state_nxt = S_FIN;
        if (sts_i.rd_rem_zero) begin
          // Zero length packet: close it at once.
          if (!sts_i.fill_zero && sts_i.rd_is_trl) begin
            cmd_o.pop = 1'b1;
          end
          cmd_o.clr_pkt = 1'b1;
        end else if (!sts_i.fill_zero) begin
          cmd_o.pop       = 1'b1;
          cmd_o.set_dout  = 1'b1;
          cmd_o.dec_rd    = 1'b1;
          cmd_o.mark_last = sts_i.rd_rem_one;
          if (sts_i.rd_rem_one) begin
            state_nxt = S_RD_TRL;
          end
        end
      end

      S_RD_TRL: begin
        if (!sts_i.fill_zero && sts_i.rd_is_trl) begin
          cmd_o.pop = 1'b1;
        end
        cmd_o.clr_pkt = 1'b1;
        state_nxt     = S_FIN;
      end

      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hw/rtl/framed_packet_ring_buffer.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake            | Word
// in_      | input     | in_valid / in_ready   | func, packet_len, data_in
// out_     | output    | out_valid / out_ready | data, flags, length, status, usage
// cfg_     | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// A word passes through accept, execute, status update and output load, with more
// steps for store accesses beyond execute: a written byte may add the trailer, a
// packet start adds header and length and may add the trailer, a framed read adds
// the data step and may add dropped bytes, header, length and trailer; raw reads none.
// Reset is synchronous and needs no clearing pass: store entries outside the fill
// window are never read. The output register lets the next word be taken while the
// previous result waits; a held result stalls the block only at its next result.
module framed_packet_ring_buffer import fprb_pkg::*; #(
  parameter int DEPTH = FPRB_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_func,
  input  logic [7:0]            in_packet_len,
  input  logic [7:0]            in_data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            out_data_out,
  output logic                  out_data_valid,
  output logic                  out_last_byte,
  output logic [7:0]            out_packet_length,
  output logic [1:0]            out_buffer_status,
  output logic [6:0]            out_usage_percent,
  output logic                  out_overflow,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  fprb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  // Store, pointers, counters and output register.
  fprb_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_packet_len     (in_packet_len),
    .in_data_in        (in_data_in),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_data_out      (out_data_out),
    .out_data_valid    (out_data_valid),
    .out_last_byte     (out_last_byte),
    .out_packet_length (out_packet_length),
    .out_buffer_status (out_buffer_status),
    .out_usage_percent (out_usage_percent),
    .out_overflow      (out_overflow)
  );

endmodule
